// ----- sv/clsr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the combined LCG shuffle generator.
package clsr_pkg;

  localparam int DATA_W = 31;
  localparam int MUL_W  = 16;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [MUL_W-1:0]  mult_t;

  localparam word_t MOD_A       = 31'd2147483563;
  localparam word_t MOD_B       = 31'd2147483399;
  localparam mult_t MUL_A       = 16'd40014;
  localparam mult_t MUL_B       = 16'd40692;
  localparam word_t SPAN        = 31'd2147483562;
  localparam word_t SECOND_INIT = 31'd123456789;

  localparam int TABLE_SIZE_DEF = 32;
  localparam int WARMUP         = 8;

endpackage

// ----- sv/clsr_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module clsr_ram #(
  parameter int WIDTH  = 31,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/clsr_mulmod.sv -----
`timescale 1ns / 1ps
// Constant modular multiply (MUL * x mod MOD); the product is registered and reduced combinationally.
module clsr_mulmod import clsr_pkg::*; #(
  parameter mult_t MUL = MUL_A,
  parameter word_t MOD = MOD_A
) (
  input  logic  clk,
  input  word_t operand,
  output word_t result
);

  localparam int PROD_W = DATA_W + MUL_W;
  // 2^31 mod MOD: the high part of the product folds back with this weight
  localparam logic [DATA_W:0] FOLD = {1'b1, {DATA_W{1'b0}}} - {1'b0, MOD};

  logic [PROD_W-1:0] prod_r;
  logic [DATA_W:0]   hi_ext;
  logic [DATA_W:0]   folded;
  logic [DATA_W:0]   sum;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(MUL) * PROD_W'(operand);
  end

  always_comb begin
    hi_ext = (DATA_W + 1)'(prod_r[PROD_W-1:DATA_W]);
    folded = hi_ext * FOLD;
    // sum stays below twice the modulus, so one subtract finishes it
    sum    = {1'b0, prod_r[DATA_W-1:0]} + folded;
    if (sum >= {1'b0, MOD}) begin
      result = DATA_W'(sum - {1'b0, MOD});
    end else begin
      result = DATA_W'(sum);
    end
  end

endmodule

// ----- sv/clsr_bin_index.sv -----
`timescale 1ns / 1ps
// Maps the previous deviate to a shuffle table slot by constant thresholds.
module clsr_bin_index import clsr_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
  input  word_t            value,
  output logic [IDX_W-1:0] index
);

  localparam longint BIN_W = 1 + longint'(SPAN) / TABLE_SIZE;

  // highest bin whose lower bound the value reaches; tops out at TABLE_SIZE-1
  always_comb begin
    index = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if (longint'(value) >= longint'(k) * BIN_W) begin
        index = IDX_W'(k);
      end
    end
  end

endmodule

// ----- sv/combined_lcg_shuffle_rng.sv -----
`timescale 1ns / 1ps
// Top level: two-generator combined LCG with a shuffle table held in RAM.
//
// Each input word yields one 31-bit deviate in 1..2147483562 (divide by
// 2147483563 for a uniform value). A next command runs through an accept
// step, then multiply and table read, modular reduce, and combine with table
// write-back; the rate is set by the dependent table read-modify-write around
// the registered modular multiply units, and the combine step waits while the
// output register is still held. A seed command (or a next command before any
// seed) first steps the first generator TABLE_SIZE+8 times and fills the table
// on the way. The result sits in an output register, so a new word is taken
// while the last deviate waits.
module combined_lcg_shuffle_rng import clsr_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  in_cmd,
  input  word_t in_seed_magnitude,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t out_deviate
);

  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int SEED_STEPS = TABLE_SIZE + WARMUP;
  localparam int CNT_W      = $clog2(SEED_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_STEP_MUL,
    ST_STEP_RED,
    ST_STEP_OUT
  } state_t;

  state_t            state_r, state_nxt;
  word_t             first_gen_r, first_gen_nxt;
  word_t             second_gen_r, second_gen_nxt;
  word_t             last_output_r, last_output_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  word_t             out_deviate_r, out_deviate_nxt;

  word_t             step_a;
  word_t             step_b;
  word_t             seed_val;
  logic [IDX_W-1:0]  bin_idx;
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  word_t             ram_wdata;
  word_t             ram_rdata;
  logic [DATA_W:0]   diff;
  logic [DATA_W:0]   y_full;
  word_t             y;

  clsr_mulmod #(.MUL(MUL_A), .MOD(MOD_A)) u_gen_a (
    .clk     (clk),
    .operand (first_gen_r),
    .result  (step_a)
  );

  clsr_mulmod #(.MUL(MUL_B), .MOD(MOD_B)) u_gen_b (
    .clk     (clk),
    .operand (second_gen_r),
    .result  (step_b)
  );

  clsr_bin_index #(.TABLE_SIZE(TABLE_SIZE), .IDX_W(IDX_W)) u_bin_index (
    .value (last_output_r),
    .index (bin_idx)
  );

  clsr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE), .ADDR_W(IDX_W)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (bin_idx),
    .rdata (ram_rdata)
  );

  assign seed_val  = (in_cmd && in_seed_magnitude != '0) ? in_seed_magnitude : word_t'(1);
  assign ram_waddr = (state_r == ST_STEP_OUT) ? idx_r : cnt_r[IDX_W-1:0];
  assign ram_wdata = (state_r == ST_STEP_OUT) ? first_gen_r : step_a;

  // table entry minus second generator, wrapped into 1..SPAN
  always_comb begin
    diff = {1'b0, ram_rdata} - {1'b0, second_gen_r};
    if (diff[DATA_W] || diff == '0) begin
      y_full = diff + {1'b0, SPAN};
    end else begin
      y_full = diff;
    end
    y = y_full[DATA_W-1:0];
  end

  always_comb begin
    state_nxt       = state_r;
    first_gen_nxt   = first_gen_r;
    second_gen_nxt  = second_gen_r;
    last_output_nxt = last_output_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_deviate_nxt = out_deviate_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd || first_gen_r == '0) begin
            first_gen_nxt  = seed_val;
            second_gen_nxt = seed_val;
            cnt_nxt        = CNT_W'(SEED_STEPS - 1);
            state_nxt      = ST_SEED_MUL;
          end else begin
            state_nxt = ST_STEP_MUL;
          end
        end
      end
      ST_SEED_MUL: begin
        state_nxt = ST_SEED_RED;
      end
      ST_SEED_RED: begin
        first_gen_nxt = step_a;
        // warm-up steps are dropped; the rest fill the table top down
        if (cnt_r < CNT_W'(TABLE_SIZE)) begin
          ram_we = 1'b1;
        end
        if (cnt_r == '0) begin
          last_output_nxt = step_a;
          state_nxt       = ST_STEP_MUL;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_STEP_MUL: begin
        ram_re    = 1'b1;
        idx_nxt   = bin_idx;
        state_nxt = ST_STEP_RED;
      end
      ST_STEP_RED: begin
        first_gen_nxt  = step_a;
        second_gen_nxt = step_b;
        state_nxt      = ST_STEP_OUT;
      end
      ST_STEP_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          ram_we          = 1'b1;
          last_output_nxt = y;
          out_valid_nxt   = 1'b1;
          out_deviate_nxt = y;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      first_gen_r   <= '0;
      second_gen_r  <= SECOND_INIT;
      last_output_r <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      first_gen_r   <= first_gen_nxt;
      second_gen_r  <= second_gen_nxt;
      last_output_r <= last_output_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    out_deviate_r <= out_deviate_nxt;
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_deviate = out_deviate_r;

  a_out_from_combine: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_STEP_OUT)
    else $error("output word raised outside the combine step");

  a_gen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP_OUT |-> (first_gen_r < MOD_A) && (second_gen_r < MOD_B))
    else $error("generator state not reduced below its modulus");

  a_index_source: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP_MUL |-> last_output_r < MOD_A)
    else $error("table index taken from an out-of-range value");

  a_deviate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_deviate_r != '0) && (out_deviate_r <= SPAN))
    else $error("deviate outside 1..SPAN");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for combined_lcg_shuffle_rng: reseeds, deviates and random flow control.
module testbench;
  import clsr_pkg::*;

  localparam longint QUO_A         = 53668;
  localparam longint QUO_B         = 52774;
  localparam longint REM_A         = 12211;
  localparam longint REM_B         = 3791;
  localparam int     SLOTS         = TABLE_SIZE_DEF;
  localparam longint BIN_WIDTH     = 1 + longint'(SPAN) / SLOTS;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     PHASE_WORDS   = 482;
  localparam int     SETTLE_CYCLES = 2 * (SLOTS + WARMUP) + 40;

  typedef struct packed {
    logic  cmd;
    word_t magnitude;
  } gen_word_t;

  logic  clk               = 1'b0;
  logic  rst_n             = 1'b0;
  logic  in_valid          = 1'b0;
  logic  in_cmd            = 1'b0;
  word_t in_seed_magnitude = '0;
  logic  out_stall         = 1'b0;
  logic  in_stall;
  logic  out_valid;
  word_t out_deviate;

  // predicted generator state
  word_t gen_a    = '0;
  word_t gen_b    = SECOND_INIT;
  word_t last_dev = '0;
  word_t shuffle [SLOTS];

  gen_word_t words_to_send [$];
  word_t     deviates_due [$];

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  logic hold_req       = 1'b0;
  int   n_sent         = 0;
  int   n_reseeds      = 0;
  int   n_checked      = 0;
  int   n_errors       = 0;

  combined_lcg_shuffle_rng uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_seed_magnitude (in_seed_magnitude),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_deviate       (out_deviate)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint gen_a_next(longint x);
    longint q, v;
    q = x / QUO_A;
    v = longint'(MUL_A) * (x - q * QUO_A) - q * REM_A;
    if (v < 0) v += longint'(MOD_A);
    return v;
  endfunction

  function automatic longint gen_b_next(longint x);
    longint q, v;
    q = x / QUO_B;
    v = longint'(MUL_B) * (x - q * QUO_B) - q * REM_B;
    if (v < 0) v += longint'(MOD_B);
    return v;
  endfunction

  // Load both generators, warm up, and fill the table from the top down.
  function automatic void reseed_generators(word_t s);
    longint a;
    a = (s == '0) ? 1 : longint'(s);
    gen_b = word_t'(a);
    for (int i = SLOTS + WARMUP - 1; i >= 0; i--) begin
      a = gen_a_next(a);
      if (i < SLOTS) shuffle[i] = word_t'(a);
    end
    gen_a = word_t'(a);
    last_dev = shuffle[0];
  endfunction

  function automatic word_t predict_deviate(logic cmd, word_t magnitude);
    longint y, slot;
    if (cmd) reseed_generators(magnitude);
    else if (gen_a == '0) reseed_generators(word_t'(1));
    gen_a = word_t'(gen_a_next(longint'(gen_a)));
    gen_b = word_t'(gen_b_next(longint'(gen_b)));
    slot = longint'(last_dev) / BIN_WIDTH;
    if (slot >= SLOTS) slot = SLOTS - 1;
    y = longint'(shuffle[slot]) - longint'(gen_b);
    shuffle[slot] = gen_a;
    if (y < 1) y += longint'(SPAN);
    last_dev = word_t'(y);
    return last_dev;
  endfunction

  function automatic gen_word_t random_word();
    gen_word_t w;
    w.cmd = ($urandom_range(99) < 8);
    case ($urandom_range(9))
      0: w.magnitude = word_t'($urandom_range(3));
      1: w.magnitude = word_t'(MOD_A - 1 + $urandom_range(2));
      2: w.magnitude = word_t'(MOD_B - 1 + $urandom_range(2));
      default: w.magnitude = word_t'($urandom);
    endcase
    return w;
  endfunction

  task automatic push_word(logic cmd, word_t magnitude);
    gen_word_t w;
    w.cmd = cmd;
    w.magnitude = magnitude;
    words_to_send.push_back(w);
  endtask

  task automatic drain_all();
    while (words_to_send.size() != 0 || in_valid || deviates_due.size() != 0)
      @(negedge clk);
  endtask

  // Driver: predict on accept, then offer the next word unless idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deviates_due.push_back(predict_deviate(in_cmd, in_seed_magnitude));
        n_sent++;
        if (in_cmd) n_reseeds++;
      end
      if (!in_valid || !in_stall) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid          <= 1'b1;
          in_cmd            <= words_to_send[0].cmd;
          in_seed_magnitude <= words_to_send[0].magnitude;
          void'(words_to_send.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold, started by a one-cycle request.
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each deviate taken from the output with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (deviates_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected deviate %0d at %0t", out_deviate, $realtime);
        end else begin
          if (out_deviate !== deviates_due[0]) begin
            n_errors++;
            if (n_errors <= 10)
              $display("deviate mismatch at %0t: expected %0d got %0d",
                       $realtime, deviates_due[0], out_deviate);
          end
          void'(deviates_due.pop_front());
          n_checked++;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) shuffle[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // next before any seed falls back to a seed of one
    push_word(1'b0, 31'h7FFFFFFF);
    push_word(1'b0, '0);
    push_word(1'b1, '0);
    push_word(1'b0, word_t'($urandom));
    push_word(1'b1, word_t'(1));
    push_word(1'b1, 31'h7FFFFFFF);
    push_word(1'b0, '0);
    // a seed at the first modulus zeroes the first generator
    push_word(1'b1, MOD_A);
    push_word(1'b0, 31'h7FFFFFFF);
    push_word(1'b0, '0);
    // a seed at the second modulus zeroes the second generator
    push_word(1'b1, MOD_B);
    push_word(1'b0, '0);
    push_word(1'b0, 31'h7FFFFFFF);
    push_word(1'b1, word_t'(MOD_A - 1));
    push_word(1'b1, word_t'(MOD_B - 1));
    push_word(1'b1, word_t'(MOD_A + 1));
    push_word(1'b1, SPAN);
    push_word(1'b1, word_t'(12345));
    push_word(1'b0, 31'h2AAAAAAA);
    push_word(1'b0, 31'h55555555);
    push_word(1'b0, 31'h2AAAAAAA);
    push_word(1'b0, 31'h55555555);
    push_word(1'b0, 31'h7FFFFFFF);
    drain_all();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      repeat (PHASE_WORDS) words_to_send.push_back(random_word());
      if (p == 0) begin
        // hold the output while the sender keeps going, so the input backs up
        while (n_sent < 60) @(negedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
      end
      drain_all();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (deviates_due.size() != 0) begin
      n_errors++;
      $display("%0d predicted deviates never arrived", deviates_due.size());
    end
    $display("Sent %0d words (%0d reseeds) and checked %0d deviates, %0d errors.",
             n_sent, n_reseeds, n_checked, n_errors);
    $display("Flow: free-running, sender gaps, receiver stalls, both, and a %0d-cycle hold.",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("combined_lcg_shuffle_rng verification clean");
    end else begin
      $display("combined_lcg_shuffle_rng verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d deviates outstanding", deviates_due.size());
    $display("combined_lcg_shuffle_rng verification failed");
    $finish;
  end

endmodule

// ----- combined_lcg_shuffle_rng.f -----
sv/clsr_pkg.sv
sv/clsr_ram.sv
sv/clsr_mulmod.sv
sv/clsr_bin_index.sv
sv/combined_lcg_shuffle_rng.sv
bench/testbench.sv
